// ===== src/tep_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the tablet event to pointer report unit.
// Used by tep_cfg, tep_div and the top level; depends on nothing else.
package tep_pkg;

    localparam int COORD_BITS = 14;
    localparam int SIZE_BITS  = 15;
    localparam int QUOT_BITS  = 15;
    localparam int AXIS_BITS  = 32;
    localparam int PROD_BITS  = AXIS_BITS + SIZE_BITS;
    localparam int CNT_BITS   = $clog2(QUOT_BITS);
    localparam int ADDR_BITS  = 5;

    // Event classes and codes.
    localparam logic [15:0] EV_SYN           = 16'h0000;
    localparam logic [15:0] EV_KEY           = 16'h0001;
    localparam logic [15:0] EV_REL           = 16'h0002;
    localparam logic [15:0] EV_ABS           = 16'h0003;
    localparam logic [15:0] SYNC_CODE_REPORT = 16'h0000;
    localparam logic [15:0] ABS_X            = 16'h0000;
    localparam logic [15:0] ABS_Y            = 16'h0001;
    localparam logic [15:0] CODE_LEFT_KEY    = 16'h0110;
    localparam logic [15:0] CODE_RIGHT_KEY   = 16'h0111;
    localparam logic [15:0] CODE_MIDDLE_KEY  = 16'h0112;
    localparam logic [15:0] CODE_WHEEL       = 16'h0008;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_X_MIN  = 3'd0;
    localparam logic [2:0] REG_X_MAX  = 3'd1;
    localparam logic [2:0] REG_Y_MIN  = 3'd2;
    localparam logic [2:0] REG_Y_MAX  = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;

    // Reset values.
    localparam logic [AXIS_BITS-1:0] RANGE_MIN_RST = 32'd0;
    localparam logic [AXIS_BITS-1:0] RANGE_MAX_RST = 32'd32767;
    localparam logic [SIZE_BITS-1:0] WIDTH_RST     = 15'd1024;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RST    = 15'd768;
    localparam logic [AXIS_BITS-1:0] RAW_RST       = 32'd16383;

    typedef struct packed {
        logic [AXIS_BITS-1:0] x_min;
        logic [AXIS_BITS-1:0] x_max;
        logic [AXIS_BITS-1:0] y_min;
        logic [AXIS_BITS-1:0] y_max;
        logic [SIZE_BITS-1:0] width;
        logic [SIZE_BITS-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic x;
        logic y;
    } t_recentre;

    typedef struct packed {
        logic                 start;
        logic [PROD_BITS-1:0] numer;
        logic [AXIS_BITS-1:0] denom;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [QUOT_BITS-1:0] quot;
    } t_div_rsp;

endpackage

// ===== src/tep_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register bank behind an APB-style port.
// Depends on tep_pkg; flags a re-centre of an axis after a write to its range.
module tep_cfg
    import tep_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output t_cfg                 o_cfg,
    output t_recentre            o_recentre
);

    t_cfg       r_cfg;
    t_recentre  r_recentre;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_min  <= RANGE_MIN_RST;
            r_cfg.x_max  <= RANGE_MAX_RST;
            r_cfg.y_min  <= RANGE_MIN_RST;
            r_cfg.y_max  <= RANGE_MAX_RST;
            r_cfg.width  <= WIDTH_RST;
            r_cfg.height <= HEIGHT_RST;
            r_recentre   <= '0;
        end else begin
            r_recentre <= '0;
            if (w_wr) begin
                unique case (w_idx)
                    REG_X_MIN: begin
                        r_cfg.x_min  <= pwdata;
                        r_recentre.x <= 1'b1;
                    end
                    REG_X_MAX: begin
                        r_cfg.x_max  <= pwdata;
                        r_recentre.x <= 1'b1;
                    end
                    REG_Y_MIN: begin
                        r_cfg.y_min  <= pwdata;
                        r_recentre.y <= 1'b1;
                    end
                    REG_Y_MAX: begin
                        r_cfg.y_max  <= pwdata;
                        r_recentre.y <= 1'b1;
                    end
                    REG_WIDTH:  r_cfg.width  <= pwdata[SIZE_BITS-1:0];
                    REG_HEIGHT: r_cfg.height <= pwdata[SIZE_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_X_MIN:  prdata = r_cfg.x_min;
            REG_X_MAX:  prdata = r_cfg.x_max;
            REG_Y_MIN:  prdata = r_cfg.y_min;
            REG_Y_MAX:  prdata = r_cfg.y_max;
            REG_WIDTH:  prdata = {{(32-SIZE_BITS){1'b0}}, r_cfg.width};
            REG_HEIGHT: prdata = {{(32-SIZE_BITS){1'b0}}, r_cfg.height};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg      = r_cfg;
    assign o_recentre = r_recentre;

endmodule

// ===== src/tep_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tep_pkg. The caller guarantees the quotient fits in QUOT_BITS.
module tep_div
    import tep_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [AXIS_BITS-1:0] r_rem;
    logic [AXIS_BITS-1:0] r_den;
    logic [QUOT_BITS-1:0] r_low;
    logic [QUOT_BITS-1:0] r_quot;
    logic [AXIS_BITS:0]   w_trial;
    logic [AXIS_BITS:0]   w_diff;
    logic                 w_ge;

    // The remainder stays below the divisor, so one extra bit covers the shift.
    assign w_trial = {r_rem, r_low[QUOT_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = ~w_diff[AXIS_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_BITS'(QUOT_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.numer[PROD_BITS-1:QUOT_BITS];
            r_low  <= i_req.numer[QUOT_BITS-1:0];
            r_den  <= i_req.denom;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[AXIS_BITS-1:0] : w_trial[AXIS_BITS-1:0];
            r_low  <= {r_low[QUOT_BITS-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_BITS-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== src/tablet_event_to_pointer_report_unit.sv =====
`timescale 1ns / 1ps
// Top level: event decoding, pointer state, report sequencer and output stage.
// Depends on tep_pkg, tep_cfg and tep_div.

// Key, relative and absolute events are taken whenever the input is ready.
// A sync report with changes pending puts its report beat out after each
// axis in turn is clamped (ST_CLAMP), multiplied by the screen size less one
// (ST_MUL, feeding the divider) and divided (ST_DIV), all through a single
// shared bit-serial divider; then ST_DONE loads the output register. The
// input is not ready during that sequence, nor while a finished report still
// waits in the output register and another is due. A report on a degenerate
// range or a screen of one pixel or less gives 0 on that axis; otherwise the
// position saturates at 16383.
module tablet_event_to_pointer_report_unit
    import tep_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [15:0] event_code, [47:16] event_value
    input  logic [47:0]          s_axis_tdata,
    // [15:0] event class
    input  logic [15:0]          s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [13:0] pointer_x, [27:14] pointer_y, [30:28] button_mask,
    // [62:31] wheel_delta, [63] zero
    output logic [63:0]          m_axis_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLAMP = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    t_cfg      w_cfg;
    t_recentre w_recentre;
    t_div_req  w_req;
    t_div_rsp  w_rsp;

    logic [2:0]            r_state, n_state;
    logic                  r_axis;
    logic [AXIS_BITS-1:0]  r_raw_x;
    logic [AXIS_BITS-1:0]  r_raw_y;
    logic [2:0]            r_buttons;
    logic [AXIS_BITS-1:0]  r_wheel;
    logic                  r_pending;
    logic [AXIS_BITS-1:0]  r_off;
    logic [AXIS_BITS-1:0]  r_den;
    logic                  r_zero;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic                  r_m_valid;
    logic [63:0]           r_m_data;

    logic                  w_accept;
    logic [15:0]           w_type;
    logic [15:0]           w_code;
    logic [AXIS_BITS-1:0]  w_value;
    logic                  w_report;
    logic                  w_load;
    logic [2:0]            w_btn_bit;
    logic [AXIS_BITS-1:0]  w_v, w_lo, w_hi, w_span, w_diff;
    logic [SIZE_BITS-1:0]  w_size;
    logic [SIZE_BITS-1:0]  w_sm1;
    logic                  w_lt, w_gt;
    logic [PROD_BITS-1:0]  w_prod;
    logic [COORD_BITS-1:0] w_coord;
    logic [AXIS_BITS-1:0]  w_mid_x, w_mid_y;

    tep_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (w_cfg),
        .o_recentre(w_recentre)
    );

    tep_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // Midpoint lo + ((hi - lo) >> 1) modulo 2^32: a 33-bit sum, with the
    // carry flipped when the difference would have wrapped.
    function automatic logic [AXIS_BITS-1:0] mid_of(input logic [AXIS_BITS-1:0] lo,
                                                    input logic [AXIS_BITS-1:0] hi);
        logic [AXIS_BITS:0] sum;
        sum = {1'b0, lo} + {1'b0, hi};
        sum[AXIS_BITS] = sum[AXIS_BITS] ^ (hi < lo);
        return sum[AXIS_BITS:1];
    endfunction

    assign w_mid_x = mid_of(w_cfg.x_min, w_cfg.x_max);
    assign w_mid_y = mid_of(w_cfg.y_min, w_cfg.y_max);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_type        = s_axis_tuser;
    assign w_code        = s_axis_tdata[15:0];
    assign w_value       = s_axis_tdata[47:16];
    assign w_report      = (w_type == EV_SYN) && (w_code == SYNC_CODE_REPORT) && r_pending;
    assign w_load        = (r_state == ST_DONE) && (!r_m_valid || m_axis_tready);

    always_comb begin
        unique case (w_code)
            CODE_LEFT_KEY:   w_btn_bit = 3'b001;
            CODE_RIGHT_KEY:  w_btn_bit = 3'b010;
            CODE_MIDDLE_KEY: w_btn_bit = 3'b100;
            default:         w_btn_bit = 3'b000;
        endcase
    end

    // Per-axis operands for the clamp and the multiply.
    assign w_v    = r_axis ? r_raw_y : r_raw_x;
    assign w_lo   = r_axis ? w_cfg.y_min : w_cfg.x_min;
    assign w_hi   = r_axis ? w_cfg.y_max : w_cfg.x_max;
    assign w_size = r_axis ? w_cfg.height : w_cfg.width;
    assign w_lt   = $signed(w_v) < $signed(w_lo);
    assign w_gt   = $signed(w_v) > $signed(w_hi);
    assign w_span = w_hi - w_lo;
    assign w_diff = w_v - w_lo;
    assign w_sm1  = w_size - 1'b1;
    assign w_prod = r_off * w_sm1;

    assign w_req.start = (r_state == ST_MUL);
    assign w_req.numer = w_prod;
    assign w_req.denom = r_den;

    assign w_coord = r_zero ? '0 :
                     (|w_rsp.quot[QUOT_BITS-1:COORD_BITS]) ? '1 :
                     w_rsp.quot[COORD_BITS-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept && w_report) n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_MUL;
            ST_MUL:   n_state = ST_DIV;
            ST_DIV:   if (w_rsp.done) n_state = r_axis ? ST_DONE : ST_CLAMP;
            ST_DONE:  if (w_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_axis    <= 1'b0;
            r_raw_x   <= RAW_RST;
            r_raw_y   <= RAW_RST;
            r_buttons <= '0;
            r_wheel   <= '0;
            r_pending <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // A range write re-centres its axis; a later event overrides it.
            if (w_recentre.x) r_raw_x <= w_mid_x;
            if (w_recentre.y) r_raw_y <= w_mid_y;

            if (w_accept) begin
                if (w_type == EV_ABS) begin
                    if (w_code == ABS_X) begin
                        r_raw_x   <= w_value;
                        r_pending <= 1'b1;
                    end else if (w_code == ABS_Y) begin
                        r_raw_y   <= w_value;
                        r_pending <= 1'b1;
                    end
                end else if (w_type == EV_KEY) begin
                    if (|w_btn_bit) begin
                        r_buttons <= (|w_value) ? (r_buttons | w_btn_bit)
                                                : (r_buttons & ~w_btn_bit);
                        r_pending <= 1'b1;
                    end
                end else if (w_type == EV_REL && w_code == CODE_WHEEL) begin
                    r_wheel   <= r_wheel + w_value;
                    r_pending <= 1'b1;
                end else if (w_report) begin
                    r_axis <= 1'b0;
                end
            end

            if (r_state == ST_DIV && w_rsp.done) r_axis <= 1'b1;

            if (w_load) begin
                r_wheel   <= '0;
                r_pending <= 1'b0;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLAMP) begin
            r_off  <= w_lt ? '0 : (w_gt ? w_span : w_diff);
            r_den  <= w_span;
            r_zero <= !($signed(w_hi) > $signed(w_lo)) || (w_size[SIZE_BITS-1:1] == '0);
        end
        if (r_state == ST_DIV && w_rsp.done) begin
            if (r_axis) r_py <= w_coord;
            else        r_px <= w_coord;
        end
        if (w_load) begin
            r_m_data <= {1'b0, r_wheel, r_buttons, r_py, r_px};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

`ifndef SYNTHESIS
    a_busy_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_report) |=> !s_axis_tready)
        else $error("input still ready after a report was started");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide step");

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_wheel == '0 && !r_pending && m_axis_tvalid))
        else $error("report did not clear the wheel sum and pending flag");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_DONE))
        else $error("report beat raised without a finished report");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for tablet_event_to_pointer_report_unit: streams event beats in,
// predicts pointer reports in a scoreboard class and checks every report beat.
// Depends on tep_pkg and the unit itself.
module tb;
    import tep_pkg::*;

    localparam int SETTLE_CYCLES   = 64;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int PHASES          = 6;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Report beat layout, lowest field last.
    typedef struct packed {
        logic                  pad;
        logic [31:0]           wheel;
        logic [2:0]            buttons;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } t_pointer_report;

    class t_report_board;
        localparam logic [2:0]  MASK_LEFT   = 3'b001;
        localparam logic [2:0]  MASK_RIGHT  = 3'b010;
        localparam logic [2:0]  MASK_MIDDLE = 3'b100;
        localparam logic [63:0] COORD_MAX   = (64'd1 << COORD_BITS) - 64'd1;

        logic [31:0]          x_min, x_max, y_min, y_max;
        logic [SIZE_BITS-1:0] width, height;
        logic [31:0]          pos_x, pos_y, wheel_sum;
        logic [2:0]           buttons;
        bit                   pending;
        t_pointer_report      due_q[$];
        int                   reports_seen;

        function new();
            x_min = RANGE_MIN_RST;
            x_max = RANGE_MAX_RST;
            y_min = RANGE_MIN_RST;
            y_max = RANGE_MAX_RST;
            width = WIDTH_RST;
            height = HEIGHT_RST;
            pos_x = centre(x_min, x_max);
            pos_y = centre(y_min, y_max);
            buttons = '0;
            wheel_sum = '0;
            pending = 1'b0;
            reports_seen = 0;
        endfunction

        function logic [31:0] centre(logic [31:0] lo, logic [31:0] hi);
            logic [31:0] span;
            span = hi - lo;
            return lo + (span >> 1);
        endfunction

        function logic [COORD_BITS-1:0] scale_axis(logic [31:0] raw, logic [31:0] lo,
                                                   logic [31:0] hi, logic [SIZE_BITS-1:0] size);
            logic [31:0] pos, offs, span, size_m1;
            logic [63:0] quot;
            if (size <= 1 || $signed(hi) <= $signed(lo))
                return '0;
            pos = raw;
            if ($signed(pos) < $signed(lo))
                pos = lo;
            if ($signed(pos) > $signed(hi))
                pos = hi;
            offs = pos - lo;
            span = hi - lo;
            size_m1 = {17'd0, size} - 32'd1;
            quot = ({32'd0, offs} * {32'd0, size_m1}) / {32'd0, span};
            quot = {32'd0, quot[31:0]};
            if (quot >= {49'd0, size})
                quot = {32'd0, size_m1};
            if (quot > COORD_MAX)
                return '1;
            return quot[COORD_BITS-1:0];
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_X_MIN: begin
                    x_min = value;
                    pos_x = centre(x_min, x_max);
                end
                REG_X_MAX: begin
                    x_max = value;
                    pos_x = centre(x_min, x_max);
                end
                REG_Y_MIN: begin
                    y_min = value;
                    pos_y = centre(y_min, y_max);
                end
                REG_Y_MAX: begin
                    y_max = value;
                    pos_y = centre(y_min, y_max);
                end
                REG_WIDTH:  width = value[SIZE_BITS-1:0];
                REG_HEIGHT: height = value[SIZE_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void note_event(logic [15:0] ev_type, logic [15:0] ev_code,
                                 logic [31:0] ev_value);
            logic [2:0]      btn;
            t_pointer_report due;
            btn = '0;
            if (ev_type == EV_ABS) begin
                if (ev_code == ABS_X) begin
                    pos_x = ev_value;
                    pending = 1'b1;
                end else if (ev_code == ABS_Y) begin
                    pos_y = ev_value;
                    pending = 1'b1;
                end
            end else if (ev_type == EV_KEY) begin
                case (ev_code)
                    CODE_LEFT_KEY:   btn = MASK_LEFT;
                    CODE_RIGHT_KEY:  btn = MASK_RIGHT;
                    CODE_MIDDLE_KEY: btn = MASK_MIDDLE;
                    default:         btn = '0;
                endcase
                if (btn != '0) begin
                    if (ev_value != '0)
                        buttons = buttons | btn;
                    else
                        buttons = buttons & ~btn;
                    pending = 1'b1;
                end
            end else if (ev_type == EV_REL && ev_code == CODE_WHEEL) begin
                wheel_sum = wheel_sum + ev_value;
                pending = 1'b1;
            end else if (ev_type == EV_SYN && ev_code == SYNC_CODE_REPORT && pending) begin
                due.pad = 1'b0;
                due.x = scale_axis(pos_x, x_min, x_max, width);
                due.y = scale_axis(pos_y, y_min, y_max, height);
                due.buttons = buttons;
                due.wheel = wheel_sum;
                due_q.push_back(due);
                wheel_sum = '0;
                pending = 1'b0;
            end
        endfunction

        function bit check_report(t_pointer_report got, output string msg);
            t_pointer_report want;
            msg = "";
            if (due_q.size() == 0) begin
                msg = $sformatf("report beat %h arrived with none outstanding", got);
                return 1'b0;
            end
            want = due_q.pop_front();
            reports_seen++;
            if (got.x !== want.x)
                msg = {msg, $sformatf(" pointer_x %0d/%0d", got.x, want.x)};
            if (got.y !== want.y)
                msg = {msg, $sformatf(" pointer_y %0d/%0d", got.y, want.y)};
            if (got.buttons !== want.buttons)
                msg = {msg, $sformatf(" button_mask %b/%b", got.buttons, want.buttons)};
            if (got.wheel !== want.wheel)
                msg = {msg, $sformatf(" wheel_delta %h/%h", got.wheel, want.wheel)};
            if (got.pad !== want.pad)
                msg = {msg, $sformatf(" pad %b/0", got.pad)};
            if (msg == "")
                return 1'b1;
            msg = {$sformatf("report %0d differs (got/expected):", reports_seen), msg};
            return 1'b0;
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata  = '0;   // [15:0] event_code, [47:16] event_value
    logic [15:0]          s_axis_tuser  = '0;   // [15:0] event class
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [13:0] pointer_x, [27:14] pointer_y, [30:28] button_mask, [62:31] wheel_delta
    logic [63:0]          m_axis_tdata;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [31:0]          pwdata  = '0;
    logic [31:0]          prdata;
    logic                 pready;

    t_report_board board;
    int          src_idle  = 21;
    int          sink_idle = 68;
    int          errors    = 0;
    int          events_sent = 0;
    int          reg_writes  = 0;
    string       check_msg;

    tablet_event_to_pointer_report_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (!board.check_report(t_pointer_report'(m_axis_tdata), check_msg))
                flag_mismatch(check_msg);
        end
    end

    task automatic send_event(input logic [15:0] ev_type, input logic [15:0] ev_code,
                              input logic [31:0] ev_value);
        if ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ev_type;
        s_axis_tdata  <= {ev_value, ev_code};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        board.note_event(ev_type, ev_code, ev_value);
        events_sent++;
    endtask

    // Drops valid and waits on the clock before checking, so valid never drops and rises in one step.
    task automatic wait_for_reports();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.due_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic drain();
        wait_for_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, value);
        reg_writes++;
    endtask

    function automatic logic [31:0] pick_position(logic [31:0] lo, logic [31:0] hi);
        logic [31:0] span;
        span = hi - lo;
        case ($urandom_range(0, 9))
            0: return lo;
            1: return hi;
            2: return lo - 32'd1;
            3: return hi + 32'd1;
            4: return 32'h8000_0000;
            5: return 32'h7fff_ffff;
            6: return $urandom;
            default: return (span == '1) ? $urandom : lo + ($urandom % (span + 32'd1));
        endcase
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 6))
            0: return 32'd1;
            1: return 32'd2;
            2: return 32'd16384;
            3: return 32'd16383;
            default: return $urandom_range(1, 16384);
        endcase
    endfunction

    task automatic write_random_range(input logic [2:0] lo_reg, input logic [2:0] hi_reg);
        logic [31:0] lo, hi;
        case ($urandom_range(0, 4))
            0: begin
                lo = $urandom_range(0, 2000) - 1000;
                hi = lo + $urandom_range(1, 64);
            end
            1: begin
                lo = $urandom;
                hi = $urandom;
            end
            2: begin
                lo = '0;
                hi = $urandom_range(1, 65535);
            end
            3: begin
                lo = -$urandom_range(1, 1 << 20);
                hi = $urandom_range(0, 1 << 20);
            end
            default: begin
                // Empty or reversed range: the axis reports zero unless hi wraps past the signed limit.
                lo = $urandom;
                hi = lo - $urandom_range(0, 100);
            end
        endcase
        write_reg(lo_reg, lo);
        write_reg(hi_reg, hi);
    endtask

    task automatic configure(input int phase);
        case (phase)
            0: begin
                write_reg(REG_X_MIN, 32'h8000_0000);
                write_reg(REG_X_MAX, 32'h7fff_ffff);
                write_reg(REG_Y_MIN, 32'd5);
                write_reg(REG_Y_MAX, 32'd5);
                write_reg(REG_WIDTH, 32'd16384);
                write_reg(REG_HEIGHT, 32'd1);
            end
            1: begin
                write_reg(REG_X_MIN, 32'd100);
                write_reg(REG_X_MAX, -32'sd100);
                write_reg(REG_Y_MIN, -32'sd1000);
                write_reg(REG_Y_MAX, 32'd1000);
                write_reg(REG_WIDTH, 32'd2);
                write_reg(REG_HEIGHT, 32'd16383);
                write_reg(REG_UNUSED, $urandom);
            end
            default: begin
                write_random_range(REG_X_MIN, REG_X_MAX);
                write_random_range(REG_Y_MIN, REG_Y_MAX);
                write_reg(REG_WIDTH, pick_size());
                write_reg(REG_HEIGHT, pick_size());
            end
        endcase
    endtask

    task automatic send_update();
        logic [31:0] value;
        case ($urandom_range(0, 5))
            0: send_event(EV_ABS, ABS_X, pick_position(board.x_min, board.x_max));
            1: send_event(EV_ABS, ABS_Y, pick_position(board.y_min, board.y_max));
            2, 3, 4: begin
                value = ($urandom_range(1) == 0) ? 32'd0 : ($urandom | 32'd1);
                case ($urandom_range(0, 2))
                    0: send_event(EV_KEY, CODE_LEFT_KEY, value);
                    1: send_event(EV_KEY, CODE_RIGHT_KEY, value);
                    default: send_event(EV_KEY, CODE_MIDDLE_KEY, value);
                endcase
            end
            default: begin
                value = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 10) - 5;
                send_event(EV_REL, CODE_WHEEL, value);
            end
        endcase
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 5))
            0: send_event($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom);
            1: send_event(EV_SYN, $urandom_range(1, 65535), $urandom);
            2: send_event(EV_SYN, SYNC_CODE_REPORT, $urandom);
            3: send_event(EV_KEY, $urandom_range(16'h0100, 16'h011f), $urandom);
            4: send_event(EV_ABS, $urandom_range(2, 65535), $urandom);
            default: send_event(EV_REL, $urandom_range(0, 65535), $urandom);
        endcase
    endtask

    task automatic random_items(input int count);
        int sent;
        int updates;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 3)
                wait_for_reports();
            if ($urandom_range(99) < 85) begin
                updates = $urandom_range(1, 4);
                repeat (updates) send_update();
                send_event(EV_SYN, SYNC_CODE_REPORT, $urandom);
                sent += updates + 1;
            end else begin
                send_noise();
                sent++;
            end
        end
    endtask

    task automatic directed_items();
        send_event(EV_SYN, SYNC_CODE_REPORT, 32'd0);           // nothing pending yet
        send_event(EV_REL, CODE_WHEEL, 32'd1);
        send_event(EV_SYN, SYNC_CODE_REPORT, 32'hffff_ffff);   // reset midpoints
        send_event(EV_ABS, ABS_X, 32'h8000_0000);
        send_event(EV_ABS, ABS_Y, 32'h7fff_ffff);
        send_event(EV_SYN, SYNC_CODE_REPORT, 32'd0);
        send_event(EV_KEY, CODE_LEFT_KEY, 32'd1);
        send_event(EV_KEY, CODE_RIGHT_KEY, 32'hffff_ffff);
        send_event(EV_KEY, CODE_MIDDLE_KEY, 32'h8000_0000);
        send_event(EV_SYN, SYNC_CODE_REPORT, 32'd0);
        send_event(EV_KEY, CODE_RIGHT_KEY, 32'd0);
        send_event(EV_REL, CODE_WHEEL, 32'h7fff_ffff);
        send_event(EV_REL, CODE_WHEEL, 32'd1);                 // wheel sum wraps
        send_event(EV_SYN, SYNC_CODE_REPORT, 32'd0);
        send_event(16'hffff, 16'hffff, 32'hffff_ffff);
        send_event(EV_SYN, 16'hffff, 32'd0);
        send_event(EV_KEY, 16'h0113, 32'd1);
        send_event(EV_ABS, 16'h0002, 32'd7);
        send_event(EV_REL, 16'h0000, 32'd3);
        send_event(EV_SYN, SYNC_CODE_REPORT, 32'd0);           // still nothing pending
        send_event(EV_ABS, ABS_X, 32'd32767);
        send_event(EV_ABS, ABS_Y, 32'd0);
        send_event(EV_SYN, SYNC_CODE_REPORT, 32'd0);
    endtask

    initial begin
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_items();
        drain();
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 2) begin
                src_idle  = 68;
                sink_idle = 21;
            end else if (phase == 4) begin
                src_idle  = 0;
                sink_idle = 0;
            end
            configure(phase);
            random_items(ITEMS_PER_PHASE);
            drain();
        end
        $display("Covered %0d events and %0d pointer reports over %0d register writes,",
                 events_sent, board.reports_seen, reg_writes);
        $display("with idle sender, idle receiver and back-to-back handshaking.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Timed out with %0d reports outstanding.", board.due_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== tablet_event_to_pointer_report_unit.f =====
src/tep_pkg.sv
src/tep_cfg.sv
src/tep_div.sv
src/tablet_event_to_pointer_report_unit.sv
bench/tb.sv
